// ===== hdl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, codes and CRC7 constants for the SD SPI command engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	localparam int POLL_W = 9;
	localparam int CNT_W  = 3;
	localparam int RESP_W = 40;

	// request and result kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_POLL  = 1'b1;
	localparam logic OUT_FRAME  = 1'b0;
	localparam logic OUT_FINISH = 1'b1;

	// expected response kinds
	localparam logic [1:0] RESP_R1  = 2'd0;
	localparam logic [1:0] RESP_R2  = 2'd1;
	localparam logic [1:0] RESP_R37 = 2'd2;
	localparam logic [1:0] RESP_NONE = 2'd3;

	localparam logic [7:0] HOST_BIT       = 8'h40;
	localparam logic [7:0] CMD0_TRAILER   = 8'h95;
	localparam logic [7:0] NO_CRC_TRAILER = 8'hFF;
	localparam logic [7:0] IDLE_BYTE      = 8'hFF;
	localparam logic [7:0] ERR_BITS       = 8'hFE;
	localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
	localparam logic [5:0] CMD_IF_COND    = 6'd8;
	localparam logic [6:0] CRC7_POLY      = 7'h09;

	localparam logic [CNT_W-1:0] FRAME_LAST_IDX = 3'd5;
	localparam logic [CNT_W-1:0] NEED_R1  = 3'd1;
	localparam logic [CNT_W-1:0] NEED_R2  = 3'd2;
	localparam logic [CNT_W-1:0] NEED_R37 = 3'd5;
	localparam logic [CNT_W-1:0] CNT_MAX  = 3'd5;

	typedef struct packed {
		logic        req_type;
		logic [5:0]  cmd_index;
		logic [31:0] argument;
		logic [1:0]  resp_kind;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [7:0]        final_byte;
		logic [RESP_W-1:0] resp_bytes;
		logic [CNT_W-1:0]  bytes_received;
		logic              timed_out;
	} fin_t;

	// Column d is x^(d+7) mod G: the CRC7 contribution of a message bit
	// followed by d more bits.
	function automatic logic [39:0][6:0] crc7_cols();
		logic [39:0][6:0] c;
		logic [6:0]       r;
		r = CRC7_POLY;
		for (int d = 0; d < 40; d++) begin
			c[d] = r;
			r = {r[5:0], 1'b0} ^ (r[6] ? CRC7_POLY : 7'h00);
		end
		return c;
	endfunction

	localparam logic [39:0][6:0] CRC7_COLS = crc7_cols();

endpackage

// ===== hdl/sdspi_frame_gen.sv =====
// ----------------------------------------------------------------------------
// sdspi_frame_gen
// Builds the six-byte command frame; the trailer is a parallel CRC7, the fixed
// CMD0 trailer, or 0xFF when CRC is off for a command other than CMD8.
module sdspi_frame_gen (
	input  logic [5:0]  cmd_index,
	input  logic [31:0] argument,
	input  logic        crc_enable,
	output logic [47:0] frame
);

	logic [39:0] msg;
	logic [6:0]  crc;
	logic [7:0]  trailer;

	assign msg = {sdspi_pkg::HOST_BIT | {2'b00, cmd_index}, argument};

	// CRC is linear: xor the column of every set message bit
	always_comb begin
		crc = 7'h00;
		for (int j = 0; j < 40; j++) begin
			if (msg[j])
				crc = crc ^ sdspi_pkg::CRC7_COLS[j];
		end
	end

	always_comb begin
		if (cmd_index == sdspi_pkg::CMD_GO_IDLE)
			trailer = sdspi_pkg::CMD0_TRAILER;
		else if (crc_enable || cmd_index == sdspi_pkg::CMD_IF_COND)
			trailer = {crc, 1'b1};
		else
			trailer = sdspi_pkg::NO_CRC_TRAILER;
	end

	assign frame = {msg, trailer};

endmodule

// ===== hdl/sdspi_resp_track.sv =====
// ----------------------------------------------------------------------------
// sdspi_resp_track
// Response collector: skips leading idle bytes, stores the response, counts polls.
// ----------------------------------------------------------------------------
module sdspi_resp_track #(
	parameter int unsigned POLL_LIMIT = 500
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  sdspi_pkg::item_t   item,
	output sdspi_pkg::fin_t    fin
);

	localparam logic [sdspi_pkg::POLL_W-1:0] LIMIT = sdspi_pkg::POLL_W'(POLL_LIMIT);
	localparam logic [sdspi_pkg::POLL_W-1:0] SAT   = '1;

	logic                              awaiting_q;
	logic [1:0]                        kind_q;
	logic [sdspi_pkg::CNT_W-1:0]       count_q;
	logic [sdspi_pkg::RESP_W-1:0]      bytes_q;
	logic [sdspi_pkg::POLL_W-1:0]      poll_q;

	logic                              store;
	logic                              done;
	logic [sdspi_pkg::POLL_W-1:0]      poll_n;
	logic [sdspi_pkg::CNT_W-1:0]       count_n;
	logic [sdspi_pkg::CNT_W-1:0]       need;
	logic [sdspi_pkg::RESP_W-1:0]      bytes_n;
	logic [7:0]                        first;
	logic                              is_poll;

	assign is_poll = (item.req_type == sdspi_pkg::REQ_POLL) && awaiting_q;
	assign poll_n  = (poll_q != SAT) ? poll_q + 1'b1 : poll_q;
	assign store   = !(item.rx_byte == sdspi_pkg::IDLE_BYTE && count_q == '0)
		&& kind_q != sdspi_pkg::RESP_NONE;

	always_comb begin
		case (kind_q)
			sdspi_pkg::RESP_R1: need = sdspi_pkg::NEED_R1;
			sdspi_pkg::RESP_R2: need = sdspi_pkg::NEED_R2;
			default:            need = sdspi_pkg::NEED_R37;
		endcase
	end

	always_comb begin
		if (store) begin
			bytes_n = {bytes_q[sdspi_pkg::RESP_W-9:0], item.rx_byte};
			count_n = (count_q < sdspi_pkg::CNT_MAX) ? count_q + 1'b1 : count_q;
		end else begin
			bytes_n = bytes_q;
			count_n = count_q;
		end
	end

	// first stored byte sits count_n-1 bytes up
	always_comb begin
		case (count_n)
			3'd2:    first = bytes_n[15:8];
			3'd3:    first = bytes_n[23:16];
			3'd4:    first = bytes_n[31:24];
			3'd5:    first = bytes_n[39:32];
			default: first = bytes_n[7:0];
		endcase
	end

	assign done = store && (count_n >= need || (first & sdspi_pkg::ERR_BITS) != 8'h00);

	always_comb begin
		fin.valid          = is_poll && (done || poll_n >= LIMIT);
		fin.final_byte     = item.rx_byte;
		fin.resp_bytes     = bytes_n;
		fin.bytes_received = count_n;
		fin.timed_out      = !done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			kind_q     <= sdspi_pkg::RESP_R1;
			count_q    <= '0;
			bytes_q    <= '0;
			poll_q     <= '0;
		end else if (advance) begin
			if (item.req_type == sdspi_pkg::REQ_START) begin
				awaiting_q <= 1'b1;
				kind_q     <= item.resp_kind;
				count_q    <= '0;
				bytes_q    <= '0;
				poll_q     <= '0;
			end else if (is_poll) begin
				poll_q  <= poll_n;
				count_q <= count_n;
				bytes_q <= bytes_n;
				if (fin.valid)
					awaiting_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/sdspi_out_buf.sv =====
// ----------------------------------------------------------------------------
// sdspi_out_buf
// Result register: shifts out six frame bytes or holds one finish result.
// ----------------------------------------------------------------------------
module sdspi_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_frame,
	input  logic [47:0]      frame,
	input  logic             load_fin,
	input  sdspi_pkg::fin_t  fin,
	output logic             free,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [63:0]      m_axis_tdata,
	output logic             m_axis_tuser,
	output logic             m_axis_tlast
);

	logic                        valid_q;
	logic                        kind_q;
	logic [sdspi_pkg::CNT_W-1:0] left_q;
	logic [47:0]                 frame_q;
	sdspi_pkg::fin_t             fin_q;
	logic                        last;
	logic                        take;

	assign last = (kind_q == sdspi_pkg::OUT_FINISH) || (left_q == '0);
	assign take = valid_q && m_axis_tready;
	assign free = !valid_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kind_q  <= sdspi_pkg::OUT_FRAME;
			left_q  <= '0;
		end else begin
			if (load_frame) begin
				valid_q <= 1'b1;
				kind_q  <= sdspi_pkg::OUT_FRAME;
				left_q  <= sdspi_pkg::FRAME_LAST_IDX;
			end else if (load_fin) begin
				valid_q <= 1'b1;
				kind_q  <= sdspi_pkg::OUT_FINISH;
			end else if (take) begin
				if (last)
					valid_q <= 1'b0;
				else
					left_q <= left_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_frame)
			frame_q <= frame;
		else if (take && !last)
			frame_q <= {frame_q[39:0], 8'h00};
		if (load_fin)
			fin_q <= fin;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last;
	assign m_axis_tdata  = (kind_q == sdspi_pkg::OUT_FINISH)
		? {4'h0, fin_q.timed_out, fin_q.bytes_received, fin_q.resp_bytes,
			fin_q.final_byte, 8'h00}
		: {56'h0, frame_q[47:40]};

endmodule

// ===== hdl/sd_spi_command_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sd_spi_command_engine_unit
// SD card SPI command framing with CRC7 and response collection.
// ----------------------------------------------------------------------------
// Input stream: a start transaction (tuser 0) carries command index, argument
// and expected response kind; a poll transaction (tuser 1) carries one byte
// read from the card. Output stream: a start yields six frame-byte
// transactions (tuser 0, tlast on the sixth); a poll that ends the response
// yields one finish transaction (tuser 1, tlast 1) with the collected bytes,
// the byte count and a timeout flag. Polls while no command is pending and
// polls that do not end the response give nothing.
// An accepted transaction passes the input register, then the result register.
// Polls pass at one transaction per cycle while the result register is free; a
// start holds it until its six frame bytes leave, one per cycle while tready is high.
// When the receiver stalls, the result register holds and the input register
// fills, then s_axis_tready drops. Reset clears crc_enable, the pending
// response and both registers' valid flags.
// crc_enable is written over the APB port at addresses 0 to 3 (paddr[2] low).
// ----------------------------------------------------------------------------
module sd_spi_command_engine_unit #(
	parameter int unsigned POLL_LIMIT = 500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // cmd_index, argument, resp_kind, rx_byte
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // tx_byte, final_byte, resp_bytes,
	                                   // bytes_received, timed_out, zero pad
	output logic        m_axis_tuser,  // out_kind
	output logic        m_axis_tlast,  // last_of_run
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic              crc_enable_q;
	logic              valid_s1;
	sdspi_pkg::item_t  item_s1;
	sdspi_pkg::fin_t   fin;
	logic [47:0]       frame;
	logic              buf_free;
	logic              advance;
	logic              is_start;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'h0, crc_enable_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			crc_enable_q <= 1'b0;
		else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
			crc_enable_q <= pwdata[0];
	end

	// input register
	assign advance       = valid_s1 && buf_free;
	assign s_axis_tready = !valid_s1 || advance;
	assign is_start      = item_s1.req_type == sdspi_pkg::REQ_START;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.req_type  <= s_axis_tuser;
			item_s1.cmd_index <= s_axis_tdata[5:0];
			item_s1.argument  <= s_axis_tdata[37:6];
			item_s1.resp_kind <= s_axis_tdata[39:38];
			item_s1.rx_byte   <= s_axis_tdata[47:40];
		end
	end

	sdspi_frame_gen u_frame (
		.cmd_index  (item_s1.cmd_index),
		.argument   (item_s1.argument),
		.crc_enable (crc_enable_q),
		.frame      (frame)
	);

	sdspi_resp_track #(
		.POLL_LIMIT (POLL_LIMIT)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.fin     (fin)
	);

	sdspi_out_buf u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_frame    (advance && is_start),
		.frame         (frame),
		.load_fin      (advance && !is_start && fin.valid),
		.fin           (fin),
		.free          (buf_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// a taken start shows its first frame byte with the host bit next cycle
	a_start_frame: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_start |=> m_axis_tvalid && m_axis_tuser == sdspi_pkg::OUT_FRAME
			&& m_axis_tdata[7:6] == 2'b01)
		else $error("start did not produce a frame byte");

	// a finish transaction is always a single-item run
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == sdspi_pkg::OUT_FINISH |-> m_axis_tlast)
		else $error("finish result without tlast");

	// back-pressure only comes from a full input register behind a busy buffer
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && !buf_free)
		else $error("input stalled without cause");

endmodule
